/* rtl/ecr_pkg.sv */
// Shared constants, codes and helper functions of the ultrasonic echo ranger.
// Used by ecr_conv, ecr_fmt and the ultrasonic_echo_ranger top level.
package ecr_pkg;

    typedef logic [1:0] phase_t;
    typedef logic [2:0] cfg_addr_t;

    localparam phase_t PH_TRIGGER = 2'd0;
    localparam phase_t PH_WAIT    = 2'd1;
    localparam phase_t PH_COUNT   = 2'd2;
    localparam phase_t PH_PAUSE   = 2'd3;

    localparam cfg_addr_t CFG_TRIGGER_TICKS   = 3'd0;
    localparam cfg_addr_t CFG_PAUSE_TICKS     = 3'd1;
    localparam cfg_addr_t CFG_LOOP_CYCLES     = 3'd2;
    localparam cfg_addr_t CFG_OFFSET_CYCLES   = 3'd3;
    localparam cfg_addr_t CFG_COUNT_LIMIT     = 3'd4;
    localparam cfg_addr_t CFG_FRACTION_DIGITS = 3'd5;

    localparam logic [10:0] MUL_K       = 11'd1715;
    localparam int          MUL_SHIFT   = 4;
    localparam int          FRAC_DIGITS = 4;
    localparam logic [2:0]  FD_MAX      = 3'd4;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_POINT = 8'h2E;

    // Decimal digits needed for any value of the given bit width.
    function automatic int ecr_digits(input int dw);
        return ((dw * 1233) >>> 12) + 1;
    endfunction

endpackage

/* rtl/ecr_conv.sv */
// Conversion engine: two registered multiplies, then a shared shift-and-adjust
// unit that turns the distance into decimal digits one bit per cycle.
// Depends on ecr_pkg.
module ecr_conv #(
    parameter int COUNT_WIDTH = 16,
    localparam int DW   = COUNT_WIDTH + 13,
    localparam int NDIG = ecr_pkg::ecr_digits(COUNT_WIDTH + 13),
    localparam int NW   = NDIG - ecr_pkg::FRAC_DIGITS,
    localparam int NWW  = $clog2(NW + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [COUNT_WIDTH-1:0] count,
    input  logic [5:0]             loop_cycles,
    input  logic [5:0]             offset_cycles,
    input  logic [2:0]             fraction_digits,
    output logic                   busy,
    output logic [4*NDIG-1:0]      bcd,
    output logic [NWW-1:0]         whole_len,
    output logic [2:0]             frac_len
);
    import ecr_pkg::*;

    localparam int CYW = COUNT_WIDTH + 6;
    localparam int PW  = CYW + 11;
    localparam int STW = $clog2(DW + 1);

    localparam logic [2:0] C_IDLE   = 3'd0;
    localparam logic [2:0] C_MUL1   = 3'd1;
    localparam logic [2:0] C_MUL2   = 3'd2;
    localparam logic [2:0] C_DABBLE = 3'd3;
    localparam logic [2:0] C_LEAD   = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [5:0]             loop_reg;
    logic [5:0]             off_reg;
    logic [2:0]             fd_reg;
    logic [CYW-1:0]         cyc_reg;
    logic [DW-1:0]          d_reg;
    logic [4*NDIG-1:0]      bcd_reg;
    logic [STW-1:0]         step_reg;
    logic [NWW-1:0]         nw_reg;

    logic [CYW-1:0]    mul1_res;
    logic [PW-1:0]     mul2_res;
    logic [4*NDIG-1:0] bcd_adj;
    logic [NWW-1:0]    nw_calc;

    always_comb begin
        mul1_res = CYW'(cnt_reg) * CYW'(loop_reg) + CYW'(off_reg);
        mul2_res = PW'(cyc_reg) * PW'(MUL_K);
        for (int i = 0; i < NDIG; i++) begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                bcd_reg[4*i +: 4] + 4'd3 : bcd_reg[4*i +: 4];
        end
        nw_calc = NWW'(1);
        for (int i = 0; i < NW; i++) begin
            if (bcd_reg[4*(i+FRAC_DIGITS) +: 4] != 4'd0) begin
                nw_calc = NWW'(i + 1);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:   if (start) state_next = C_MUL1;
            C_MUL1:   state_next = C_MUL2;
            C_MUL2:   state_next = C_DABBLE;
            C_DABBLE: if (step_reg == STW'(DW - 1)) state_next = C_LEAD;
            C_LEAD:   state_next = C_IDLE;
            default:  state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            C_IDLE: begin
                if (start) begin
                    cnt_reg  <= count;
                    loop_reg <= loop_cycles;
                    off_reg  <= offset_cycles;
                    fd_reg   <= (fraction_digits > FD_MAX) ? FD_MAX : fraction_digits;
                end
            end
            C_MUL1: begin
                cyc_reg <= mul1_res;
            end
            C_MUL2: begin
                d_reg    <= mul2_res[PW-1:MUL_SHIFT];
                bcd_reg  <= '0;
                step_reg <= '0;
            end
            C_DABBLE: begin
                bcd_reg  <= {bcd_adj[4*NDIG-2:0], d_reg[DW-1]};
                d_reg    <= {d_reg[DW-2:0], 1'b0};
                step_reg <= step_reg + STW'(1);
            end
            C_LEAD: begin
                nw_reg <= nw_calc;
            end
            default: begin
            end
        endcase
    end

    assign busy      = (state_reg != C_IDLE);
    assign bcd       = bcd_reg;
    assign whole_len = nw_reg;
    assign frac_len  = fd_reg;

endmodule

/* rtl/ecr_fmt.sv */
// Character formatter: picks the ASCII character at a given position of a
// reading from its decimal digits, and gives the reading's length. Depends on ecr_pkg.
module ecr_fmt #(
    parameter int NDIG       = 12,
    parameter int CHAR_SLOTS = 10,
    localparam int NW  = NDIG - ecr_pkg::FRAC_DIGITS,
    localparam int NWW = $clog2(NW + 1),
    localparam int CIW = $clog2(CHAR_SLOTS + 1)
) (
    input  logic [4*NDIG-1:0] bcd,
    input  logic [NWW-1:0]    whole_len,
    input  logic [2:0]        frac_len,
    input  logic [CIW-1:0]    idx,
    output logic [CIW-1:0]    total,
    output logic [7:0]        code
);
    import ecr_pkg::*;

    localparam int SW = NWW + 3;

    logic [SW-1:0] nw_ext, fd_ext, idx_ext, sum, sel, frac_pos;
    logic [3:0]    digit;

    always_comb begin
        nw_ext   = SW'(whole_len);
        fd_ext   = SW'(frac_len);
        idx_ext  = SW'(idx);
        sum      = nw_ext + ((fd_ext != '0) ? fd_ext + SW'(1) : '0);
        total    = (sum > SW'(CHAR_SLOTS)) ? CIW'(CHAR_SLOTS) : sum[CIW-1:0];
        frac_pos = idx_ext - nw_ext - SW'(1);
        if (idx_ext < nw_ext) begin
            sel = nw_ext + SW'(FRAC_DIGITS - 1) - idx_ext;
        end else begin
            sel = SW'(FRAC_DIGITS - 1) - frac_pos;
        end
        digit = 4'd0;
        for (int i = 0; i < NDIG; i++) begin
            if (sel == SW'(i)) begin
                digit = bcd[4*i +: 4];
            end
        end
        code = (idx_ext == nw_ext) ? CHAR_POINT : (CHAR_ZERO | {4'b0000, digit});
    end

endmodule

/* rtl/ultrasonic_echo_ranger.sv */
// Ultrasonic ranger controller: one input beat is one counting tick carrying the
// echo level, and every tick returns one output beat with the trigger level and,
// during the pause after a reading, one ASCII character of the distance in
// millimetres with the fraction digits. Ordinary ticks do not stall the input. The
// tick that ends a measurement starts the conversion engine, and the next tick is
// taken only once the engine is idle again: two multiplies, COUNT_WIDTH + 13
// steps of the shared shift-and-adjust unit and one step to find the leading digit.
// A beat is accepted only while the output register is empty or being read.
// Depends on ecr_pkg, ecr_conv and ecr_fmt.
module ultrasonic_echo_ranger #(
    parameter int COUNT_WIDTH = 16,
    parameter int CHAR_SLOTS  = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,      // [0] echo_level
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,      // [0] trigger_level, [8:1] char_code
    output logic [0:0]        m_tuser,      // [0] char_valid
    output logic              m_tlast,
    input  logic              cfg_wr_en,
    input  ecr_pkg::cfg_addr_t cfg_addr,
    input  logic [23:0]       cfg_wr_data
);
    import ecr_pkg::*;

    localparam int DW   = COUNT_WIDTH + 13;
    localparam int NDIG = ecr_digits(DW);
    localparam int NW   = NDIG - FRAC_DIGITS;
    localparam int NWW  = $clog2(NW + 1);
    localparam int CIW  = $clog2(CHAR_SLOTS + 1);
    localparam int LW   = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [7:0]  trig_ticks_reg;
    logic [23:0] pause_ticks_reg;
    logic [5:0]  loop_reg;
    logic [5:0]  offset_reg;
    logic [15:0] limit_reg;
    logic [2:0]  frac_reg;

    phase_t                 phase_reg, phase_next;
    logic [23:0]            ticks_reg, ticks_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [CIW-1:0]         char_next_reg, char_next_next;

    logic       out_valid_reg;
    logic       trig_out_reg, trig_out;
    logic       cval_out_reg, cval_out;
    logic [7:0] code_out_reg, code_out;
    logic       last_out_reg, last_out;

    logic                   s_acc, echo, finish, conv_start, conv_busy;
    logic [LW-1:0]          lim_ext, maxc_ext;
    logic [COUNT_WIDTH-1:0] limit, count_inc;
    logic [7:0]             trig_len;
    logic [23:0]            ticks_inc, ticks_sat;
    logic [CIW-1:0]         char_total, char_inc;
    logic [7:0]             char_code;
    logic [4*NDIG-1:0]      bcd;
    logic [NWW-1:0]         whole_len;
    logic [2:0]             frac_len;

    assign s_tready = !conv_busy && (!out_valid_reg || m_tready);
    assign s_acc    = s_tvalid && s_tready;
    assign echo     = s_tdata[0];

    always_comb begin
        lim_ext   = LW'(limit_reg);
        maxc_ext  = LW'({COUNT_WIDTH{1'b1}});
        limit     = (lim_ext < maxc_ext) ? lim_ext[COUNT_WIDTH-1:0] : maxc_ext[COUNT_WIDTH-1:0];
        count_inc = (count_reg < limit) ? count_reg + COUNT_WIDTH'(1) : count_reg;
        trig_len  = (trig_ticks_reg == 8'd0) ? 8'd1 : trig_ticks_reg;
        ticks_inc = ticks_reg + 24'd1;
        ticks_sat = (ticks_reg != 24'hFFFFFF) ? ticks_inc : ticks_reg;
        char_inc  = char_next_reg + CIW'(1);
    end

    always_comb begin
        phase_next     = phase_reg;
        ticks_next     = ticks_reg;
        count_next     = count_reg;
        char_next_next = char_next_reg;
        trig_out       = 1'b0;
        cval_out       = 1'b0;
        code_out       = 8'd0;
        last_out       = 1'b0;
        finish         = 1'b0;
        unique case (phase_reg)
            PH_TRIGGER: begin
                trig_out   = 1'b1;
                count_next = '0;
                if (ticks_inc >= {16'd0, trig_len}) begin
                    phase_next = PH_WAIT;
                    ticks_next = '0;
                end else begin
                    ticks_next = ticks_inc;
                end
            end
            PH_WAIT, PH_COUNT: begin
                if (echo) begin
                    count_next = count_inc;
                    if (count_inc >= limit) begin
                        finish = 1'b1;
                    end else begin
                        phase_next = PH_COUNT;
                    end
                end else if (phase_reg == PH_COUNT) begin
                    finish = 1'b1;
                end
            end
            PH_PAUSE: begin
                if (char_next_reg < char_total) begin
                    cval_out       = 1'b1;
                    code_out       = char_code;
                    last_out       = (char_inc == char_total);
                    char_next_next = char_inc;
                end
                ticks_next = ticks_sat;
                if (ticks_sat >= pause_ticks_reg && char_next_next >= char_total) begin
                    phase_next = PH_TRIGGER;
                    ticks_next = '0;
                end
            end
            default: begin
            end
        endcase
        if (finish) begin
            phase_next     = PH_PAUSE;
            ticks_next     = '0;
            char_next_next = '0;
        end
    end

    assign conv_start = s_acc && finish;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_ticks_reg  <= 8'd18;
            pause_ticks_reg <= 24'd1777778;
            loop_reg        <= 6'd9;
            offset_reg      <= 6'd4;
            limit_reg       <= 16'd65535;
            frac_reg        <= 3'd4;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_TRIGGER_TICKS:   trig_ticks_reg  <= cfg_wr_data[7:0];
                CFG_PAUSE_TICKS:     pause_ticks_reg <= cfg_wr_data;
                CFG_LOOP_CYCLES:     loop_reg        <= cfg_wr_data[5:0];
                CFG_OFFSET_CYCLES:   offset_reg      <= cfg_wr_data[5:0];
                CFG_COUNT_LIMIT:     limit_reg       <= cfg_wr_data[15:0];
                CFG_FRACTION_DIGITS: frac_reg        <= cfg_wr_data[2:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_TRIGGER;
            ticks_reg     <= '0;
            count_reg     <= '0;
            char_next_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                phase_reg     <= phase_next;
                ticks_reg     <= ticks_next;
                count_reg     <= count_next;
                char_next_reg <= char_next_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            trig_out_reg <= trig_out;
            cval_out_reg <= cval_out;
            code_out_reg <= code_out;
            last_out_reg <= last_out;
        end
    end

    ecr_conv #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_conv (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .start           (conv_start),
        .count           (count_next),
        .loop_cycles     (loop_reg),
        .offset_cycles   (offset_reg),
        .fraction_digits (frac_reg),
        .busy            (conv_busy),
        .bcd             (bcd),
        .whole_len       (whole_len),
        .frac_len        (frac_len)
    );

    ecr_fmt #(
        .NDIG       (NDIG),
        .CHAR_SLOTS (CHAR_SLOTS)
    ) u_fmt (
        .bcd       (bcd),
        .whole_len (whole_len),
        .frac_len  (frac_len),
        .idx       (char_next_reg),
        .total     (char_total),
        .code      (char_code)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, code_out_reg, trig_out_reg};
    assign m_tuser  = cval_out_reg;
    assign m_tlast  = last_out_reg;

    a_char_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAUSE && !conv_busy) |-> (char_next_reg <= char_total))
        else $error("character index ran past the reading length");

    a_trigger_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && phase_reg == PH_TRIGGER) |=> (m_tvalid && m_tdata[0]))
        else $error("trigger tick did not drive the trigger level");

    a_start_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_start |-> (phase_reg == PH_WAIT || phase_reg == PH_COUNT))
        else $error("conversion started outside a measurement");

    a_last_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser[0])
        else $error("last marker on a beat without a character");

endmodule

/* sim/testbench.sv */
// Self-checking bench for ultrasonic_echo_ranger: sends echo ticks, predicts every output
// beat from its own model of the trigger, count, convert and print cycle, and compares them.
// Depends on ecr_pkg and the ranger RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ecr_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int COUNT_BITS    = 16;
    localparam int SLOTS         = 10;
    localparam int SETTLE_CYCLES = 48;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_TICKS   = 75;
    localparam int PRESSURE_PHASE = 2;
    localparam longint unsigned SPEED_MUL = 1715;
    localparam int SPEED_SHIFT   = 4;
    localparam int unsigned NO_READING_GOAL = 32'hFFFF_FFFF;

    typedef struct packed {
        logic       trigger;
        logic       char_valid;
        logic [7:0] char_code;
        logic       last;
    } tick_out_t;

    typedef struct {
        logic [7:0]  trigger_ticks;
        logic [23:0] pause_ticks;
        logic [5:0]  loop_cycles;
        logic [5:0]  offset_cycles;
        logic [15:0] count_limit;
        logic [2:0]  fraction_digits;
    } ranger_setting_t;

    class distance_readout;
        logic [7:0]  trigger_ticks;
        logic [23:0] pause_ticks;
        logic [5:0]  loop_cycles;
        logic [5:0]  offset_cycles;
        logic [15:0] count_limit;
        logic [2:0]  fraction_digits;

        phase_t      phase;
        int unsigned phase_ticks;
        int unsigned echo_count;
        logic [7:0]  char_buf [SLOTS];
        int unsigned char_total;
        int unsigned char_next;

        tick_out_t   pending [$];
        int unsigned errors;
        int unsigned readings;
        int unsigned compared;
        int unsigned longest_count;

        function new();
            trigger_ticks   = 8'd18;
            pause_ticks     = 24'd1777778;
            loop_cycles     = 6'd9;
            offset_cycles   = 6'd4;
            count_limit     = 16'hFFFF;
            fraction_digits = 3'd4;
            phase           = PH_TRIGGER;
            phase_ticks     = 0;
            echo_count      = 0;
            char_total      = 0;
            char_next       = 0;
            errors          = 0;
            readings        = 0;
            compared        = 0;
            longest_count   = 0;
        endfunction

        function void set_reg(cfg_addr_t addr, logic [23:0] value);
            case (addr)
                CFG_TRIGGER_TICKS:   trigger_ticks   = value[7:0];
                CFG_PAUSE_TICKS:     pause_ticks     = value;
                CFG_LOOP_CYCLES:     loop_cycles     = value[5:0];
                CFG_OFFSET_CYCLES:   offset_cycles   = value[5:0];
                CFG_COUNT_LIMIT:     count_limit     = value[15:0];
                CFG_FRACTION_DIGITS: fraction_digits = value[2:0];
                default: ;
            endcase
        endfunction

        function void put_char(logic [7:0] c);
            if (char_total < SLOTS) begin
                char_buf[char_total] = c;
                char_total++;
            end
        endfunction

        function void convert();
            longint unsigned span, distance, whole;
            int unsigned frac, scale, shown;
            string text;
            int i;
            span     = 64'(echo_count) * 64'(loop_cycles) + 64'(offset_cycles);
            distance = (span * SPEED_MUL) >> SPEED_SHIFT;
            whole    = distance / 10000;
            frac     = 32'(distance % 10000);
            text     = $sformatf("%0d", whole);
            if (echo_count > longest_count) begin
                longest_count = echo_count;
            end
            char_total = 0;
            char_next  = 0;
            for (i = 0; i < text.len(); i++) begin
                put_char(text[i]);
            end
            shown = (fraction_digits > 3'd4) ? 4 : fraction_digits;
            if (shown > 0) begin
                put_char(CHAR_POINT);
                scale = 1000;
                for (i = 0; i < shown; i++) begin
                    put_char(CHAR_ZERO + 8'((frac / scale) % 10));
                    scale = scale / 10;
                end
            end
            phase       = PH_PAUSE;
            phase_ticks = 0;
        endfunction

        function void count_echo();
            int unsigned cap;
            cap = 32'(count_limit);
            if (echo_count < cap) begin
                echo_count++;
            end
            if (echo_count >= cap) begin
                convert();
            end else begin
                phase = PH_COUNT;
            end
        endfunction

        function void take_tick(bit echo);
            tick_out_t want;
            int unsigned len;
            want = '0;
            case (phase)
                PH_WAIT: begin
                    if (echo) begin
                        count_echo();
                    end
                end
                PH_COUNT: begin
                    if (echo) begin
                        count_echo();
                    end else begin
                        convert();
                    end
                end
                PH_PAUSE: begin
                    if (char_next < char_total) begin
                        want.char_valid = 1'b1;
                        want.char_code  = char_buf[char_next];
                        want.last       = (char_next + 1 == char_total);
                        if (want.last) begin
                            readings++;
                        end
                        char_next++;
                    end
                    if (phase_ticks < 24'hFFFFFF) begin
                        phase_ticks++;
                    end
                    if (phase_ticks >= pause_ticks && char_next >= char_total) begin
                        phase       = PH_TRIGGER;
                        phase_ticks = 0;
                    end
                end
                default: begin
                    len = (trigger_ticks == 8'd0) ? 1 : trigger_ticks;
                    want.trigger = 1'b1;
                    echo_count   = 0;
                    phase_ticks++;
                    if (phase_ticks >= len) begin
                        phase       = PH_WAIT;
                        phase_ticks = 0;
                    end
                end
            endcase
            pending.push_back(want);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50) begin
                $display("MISMATCH at %0t ns: %s", $time, msg);
            end
        endtask

        task check_beat(tick_out_t got);
            tick_out_t want;
            if (pending.size() == 0) begin
                report($sformatf("output beat %h arrived with nothing expected", got));
                return;
            end
            want = pending.pop_front();
            compared++;
            if (got.trigger !== want.trigger) begin
                report($sformatf("trigger_level %b, expected %b", got.trigger, want.trigger));
            end
            if (got.char_valid !== want.char_valid) begin
                report($sformatf("char_valid %b, expected %b", got.char_valid,
                                 want.char_valid));
            end
            if (got.char_code !== want.char_code) begin
                report($sformatf("char_code %h, expected %h", got.char_code, want.char_code));
            end
            if (got.last !== want.last) begin
                report($sformatf("reading_last %b, expected %b", got.last, want.last));
            end
        endtask
    endclass

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en   = 1'b0;
    cfg_addr_t   cfg_addr    = CFG_TRIGGER_TICKS;
    logic [23:0] cfg_wr_data = '0;

    distance_readout ranger;
    bit          recv_gaps    = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned quiet_cycles = 0;
    int unsigned total_ticks  = 0;
    int unsigned settings_run = 0;

    int unsigned wait_left  = 0;
    int unsigned count_goal = 1;
    bit          noisy      = 1'b0;
    bit          fixed_plan = 1'b0;
    int unsigned fixed_wait = 0;
    int unsigned fixed_goal = 1;

    ultrasonic_echo_ranger #(
        .COUNT_WIDTH(COUNT_BITS),
        .CHAR_SLOTS (SLOTS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            ranger.check_beat({m_tdata[0], m_tuser[0], m_tdata[8:1], m_tlast});
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no beat moved for %0d cycles.", quiet_cycles);
            $display("ultrasonic_echo_ranger regression: fail");
            $finish;
        end
    end

    initial begin : result_sink
        int unsigned stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end
            stall = recv_gaps ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Echo levels follow the predicted phase so that most ticks form proper
    // readings; a noisy reading toggles the echo at random instead.
    function automatic bit next_echo();
        int unsigned pick;
        case (ranger.phase)
            PH_WAIT: begin
                if (noisy) begin
                    return 1'($urandom_range(0, 1));
                end
                if (wait_left > 0) begin
                    wait_left--;
                    return 1'b0;
                end
                return 1'b1;
            end
            PH_COUNT: begin
                if (noisy) begin
                    return 1'($urandom_range(0, 1));
                end
                return ranger.echo_count < count_goal;
            end
            PH_PAUSE: return 1'($urandom_range(0, 1));
            default: begin
                if (fixed_plan) begin
                    wait_left  = fixed_wait;
                    count_goal = fixed_goal;
                    noisy      = 1'b0;
                end else begin
                    pick = $urandom_range(0, 99);
                    count_goal = (pick < 70) ? $urandom_range(1, 20) :
                                 (pick < 95) ? $urandom_range(21, 300) :
                                               $urandom_range(301, 1500);
                    wait_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 40) :
                                                               $urandom_range(0, 3);
                    noisy      = ($urandom_range(0, 9) == 0);
                end
                return 1'($urandom_range(0, 1));
            end
        endcase
    endfunction

    function automatic ranger_setting_t random_setting();
        ranger_setting_t s;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        s.trigger_ticks = 8'((pick < 7) ? $urandom_range(0, 6) :
                             (pick < 9) ? $urandom_range(7, 30) : $urandom_range(200, 255));
        pick = $urandom_range(0, 9);
        s.pause_ticks = 24'((pick < 4) ? $urandom_range(0, 15) :
                            (pick < 9) ? $urandom_range(16, 30) : $urandom_range(31, 90));
        pick = $urandom_range(0, 7);
        s.loop_cycles = (pick == 0) ? 6'd0 : (pick == 1) ? 6'd1 :
                        (pick == 2) ? 6'd63 : 6'($urandom_range(0, 63));
        pick = $urandom_range(0, 7);
        s.offset_cycles = (pick == 0) ? 6'd0 : (pick == 1) ? 6'd63 :
                          6'($urandom_range(0, 63));
        pick = $urandom_range(0, 9);
        s.count_limit = (pick < 4) ? 16'hFFFF :
                        (pick < 7) ? 16'($urandom_range(1, 40)) :
                        (pick < 8) ? 16'($urandom_range(0, 2)) :
                                     16'($urandom_range(0, 65535));
        s.fraction_digits = 3'($urandom_range(0, 7));
        return s;
    endfunction

    task automatic write_reg(input cfg_addr_t addr, input logic [23:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= value;
        @(posedge aclk);
        ranger.set_reg(addr, value);
    endtask

    task automatic apply_setting(input ranger_setting_t s);
        write_reg(CFG_TRIGGER_TICKS,   24'(s.trigger_ticks));
        write_reg(CFG_PAUSE_TICKS,     s.pause_ticks);
        write_reg(CFG_LOOP_CYCLES,     24'(s.loop_cycles));
        write_reg(CFG_OFFSET_CYCLES,   24'(s.offset_cycles));
        write_reg(CFG_COUNT_LIMIT,     24'(s.count_limit));
        write_reg(CFG_FRACTION_DIGITS, 24'(s.fraction_digits));
        cfg_wr_en <= 1'b0;
        settings_run++;
    endtask

    task automatic send_tick(input bit echo, input int unsigned gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, echo};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ranger.take_tick(echo);
        total_ticks++;
    endtask

    task automatic wait_idle();
        while (ranger.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Runs one register setting until the tick budget is spent or the wanted
    // number of readings has been printed and a new trigger is due.
    task automatic run_phase(input ranger_setting_t s, input int unsigned max_ticks,
                             input int unsigned want_readings, input bit gaps);
        int unsigned sent;
        int unsigned first_reading;
        apply_setting(s);
        recv_gaps     = gaps;
        first_reading = ranger.readings;
        sent          = 0;
        while (sent < max_ticks &&
               !(ranger.readings - first_reading >= want_readings &&
                 ranger.phase == PH_TRIGGER)) begin
            send_tick(next_echo(), gaps ? $urandom_range(0, 7) : 0);
            sent++;
        end
        s_tvalid <= 1'b0;
        wait_idle();
    endtask

    initial begin : stimulus
        ranger_setting_t s;
        int p;
        ranger = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero trigger length, zero limit, zero loop count and no pause: prints "0".
        fixed_plan = 1'b1;
        fixed_wait = 1;
        fixed_goal = 1;
        s = '{8'd0, 24'd0, 6'd0, 6'd0, 16'd0, 3'd0};
        run_phase(s, 40, 1, 1'b0);

        // Limit reached while the echo is still high; seven fraction digits act as four.
        fixed_wait = 0;
        fixed_goal = 10;
        s = '{8'd1, 24'd0, 6'd63, 6'd63, 16'd3, 3'd7};
        run_phase(s, 40, 1, 1'b1);

        // Echo ends the count; the fraction needs leading zeros.
        fixed_wait = 2;
        fixed_goal = 2;
        s = '{8'd2, 24'd5, 6'd1, 6'd0, 16'hFFFF, 3'd4};
        run_phase(s, 40, 1, 1'b0);

        // Longest trigger, a long count that stops at the limit, and a pause
        // that outlasts the printout.
        fixed_wait = 3;
        fixed_goal = 70000;
        s = '{8'd255, 24'd64, 6'd63, 6'd63, 16'd400, 3'd4};
        run_phase(s, 255 + 3 + 400 + 64 + 40, 1, 1'b0);

        fixed_plan = 1'b0;
        for (p = 0; p < RANDOM_PHASES; p++) begin
            s = random_setting();
            if (p == PRESSURE_PHASE) begin
                hold_request = 1'b1;
            end
            run_phase(s, PHASE_TICKS, NO_READING_GOAL, $urandom_range(0, 3) != 0);
        end

        if (ranger.pending.size() != 0) begin
            ranger.report($sformatf("%0d expected beats never arrived",
                                    ranger.pending.size()));
        end
        $display("Covered %0d echo ticks over %0d register settings and %0d readings.",
                 total_ticks, settings_run, ranger.readings);
        $display("Compared %0d output beats; longest echo count %0d; %0d mismatches.",
                 ranger.compared, ranger.longest_count, ranger.errors);
        if (ranger.errors == 0) begin
            $display("ultrasonic_echo_ranger regression: pass");
        end else begin
            $display("ultrasonic_echo_ranger regression: fail");
        end
        $finish;
    end

endmodule
